@@ rtl/assert_macros.svh @@
// Assertion macros shared by the keyword substitution cipher RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every rising clock edge.
`define KSC_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define KSC_ASSERT_IMPLIES(name, cond, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/ksc_pkg.sv @@
// Package for the keyword substitution cipher: opcodes, letter constants,
// the queued command format and the queue status bundle. No dependencies.
package ksc_pkg;

    localparam int ALPHA_SIZE = 26;
    localparam int IDX_W = 5;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] LETTER_A = 8'h61;
    localparam logic [7:0] LETTER_Z = 8'h7A;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_KEY      = 2'd1,
        OP_FINISH   = 2'd2,
        OP_ENCIPHER = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             is_lower;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data_byte;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

@@ rtl/keyword_substitution_cipher_core.sv @@
// Keyword substitution cipher core. A steady stream of clear, keyword and
// encipher requests runs at one request per cycle while the output is not
// stalled; an enciphered byte is held in the queue before the back end
// loads it into the output register. A finish request holds the back end
// while it is dequeued and the back end then walks the letters from z down
// to a, since the substitution table has a single write port;
// requests behind it wait in the queue and stall the input once it fills.
// Only encipher requests produce a result.
module keyword_substitution_cipher_core #(
    parameter int QUEUE_DEPTH = ksc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] cipher_byte,
    output logic       table_ready
);
    import ksc_pkg::*;

    q_status_t q_status;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      push;
    logic      pop;

    ksc_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .data_byte (data_byte),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    ksc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    ksc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cipher_byte (cipher_byte),
        .table_ready (table_ready)
    );

endmodule

@@ rtl/ksc_front.sv @@
// Front end: accepts requests and classifies each byte as a letter index.
// Depends on ksc_pkg.
module ksc_front (
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      opcode,
    input  logic [7:0]      data_byte,
    input  ksc_pkg::q_status_t q_status,
    output logic            push,
    output ksc_pkg::cmd_t   push_cmd
);
    import ksc_pkg::*;

    logic [7:0] offset;

    assign offset = data_byte - LETTER_A;

    always_comb
    begin
        push_cmd.op        = op_t'(opcode);
        push_cmd.is_lower  = (data_byte >= LETTER_A) && (data_byte <= LETTER_Z);
        push_cmd.idx       = offset[IDX_W-1:0];
        push_cmd.data_byte = data_byte;
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

@@ rtl/ksc_queue.sv @@
// Short command queue between the front and back ends.
// Depends on ksc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ksc_queue #(
    parameter int DEPTH = ksc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ksc_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output ksc_pkg::cmd_t      head_cmd,
    output ksc_pkg::q_status_t q_status
);
    import ksc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_mem [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[tail_reg] <= push_cmd;
        end
    end

    assign head_cmd       = slot_mem[head_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));

    `KSC_ASSERT_IMPLIES(a_empty_ptrs, count_reg == '0, head_reg == tail_reg, "queue empty with pointers apart")
    `KSC_ASSERT_IMPLIES(a_full_ptrs, count_reg == CNT_W'(DEPTH), head_reg == tail_reg, "queue full with pointers apart")
    `KSC_ASSERT_IMPLIES(a_no_underflow, pop, count_reg != '0, "pop from empty queue")

endmodule

@@ rtl/ksc_back.sv @@
// Back end: owns the substitution table, used-letter map and fill count,
// walks the alphabet on finish and holds the result register.
// Depends on ksc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ksc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ksc_pkg::cmd_t      head_cmd,
    input  ksc_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         cipher_byte,
    output logic               table_ready
);
    import ksc_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN    = 2'b01,
        ST_FINISH = 2'b10
    } back_state_t;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [IDX_W-1:0]    walk_reg;
    logic [IDX_W-1:0]    walk_next;
    logic [ALPHA_SIZE-1:0] used_letters_reg;
    logic [ALPHA_SIZE-1:0] used_letters_next;
    logic [IDX_W-1:0]    fill_count_reg;
    logic [IDX_W-1:0]    fill_count_next;
    logic [IDX_W-1:0]    tbl_mem [ALPHA_SIZE];
    logic                tbl_we;
    logic                append_en;
    logic [IDX_W-1:0]    append_idx;
    logic                slot_free;
    logic                load_out;
    logic                hit;
    logic [7:0]          cipher_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          cipher_byte_reg;
    logic                table_ready_reg;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        walk_next         = walk_reg;
        used_letters_next = used_letters_reg;
        fill_count_next   = fill_count_reg;
        pop               = 1'b0;
        load_out          = 1'b0;
        append_en         = 1'b0;
        append_idx        = head_cmd.idx;
        tbl_we            = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (!q_status.empty)
                begin
                    unique case (head_cmd.op)
                        OP_CLEAR:
                        begin
                            pop               = 1'b1;
                            used_letters_next = '0;
                            fill_count_next   = '0;
                        end
                        OP_KEY:
                        begin
                            pop       = 1'b1;
                            append_en = head_cmd.is_lower;
                        end
                        OP_FINISH:
                        begin
                            pop        = 1'b1;
                            state_next = ST_FINISH;
                            walk_next  = IDX_W'(ALPHA_SIZE - 1);
                        end
                        OP_ENCIPHER:
                        begin
                            pop      = slot_free;
                            load_out = slot_free;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                append_en  = 1'b1;
                append_idx = walk_reg;
                if (walk_reg == '0)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    walk_next = walk_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (append_en && (fill_count_reg < IDX_W'(ALPHA_SIZE)))
        begin
            if (!used_letters_reg[append_idx])
            begin
                tbl_we            = 1'b1;
                fill_count_next   = fill_count_reg + 1'b1;
                used_letters_next = used_letters_reg | (ALPHA_SIZE'(1) << append_idx);
            end
        end
    end

    always_comb
    begin
        hit         = head_cmd.is_lower && (head_cmd.idx < fill_count_reg);
        cipher_next = head_cmd.data_byte;
        if (hit)
        begin
            cipher_next = LETTER_A + {3'b000, tbl_mem[head_cmd.idx]};
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            walk_reg         <= '0;
            used_letters_reg <= '0;
            fill_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            walk_reg         <= walk_next;
            used_letters_reg <= used_letters_next;
            fill_count_reg   <= fill_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[fill_count_reg] <= append_idx;
        end
        if (load_out)
        begin
            cipher_byte_reg <= cipher_next;
            table_ready_reg <= hit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_byte = cipher_byte_reg;
    assign table_ready = table_ready_reg;

    `KSC_ASSERT(a_fill_bound, fill_count_reg <= IDX_W'(ALPHA_SIZE), "fill count past alphabet")
    `KSC_ASSERT(a_fill_matches_used, $countones(used_letters_reg) == int'(fill_count_reg), "fill count disagrees with used map")
    `KSC_ASSERT_IMPLIES(a_no_pop_in_walk, state_reg == ST_FINISH, !pop, "queue popped during finish walk")

endmodule

@@ dv/keyword_substitution_cipher_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keyword_substitution_cipher_core: a directed table and
// random clear/keyword/finish/encipher sequences, checked against an in-bench model of the
// substitution table. Depends on ksc_pkg and the core RTL only.
module keyword_substitution_cipher_core_test;
    import ksc_pkg::*;

    localparam int RANDOM_REQUESTS = 1150;
    localparam int IDLE_PCT = 37;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DIRECTED_ROWS = 25;

    typedef struct {
        op_t        op;
        logic [7:0] in_byte;
        bit         typed;
        logic [7:0] want_byte;
        logic       want_ready;
    } stim_row_t;

    typedef struct {
        logic [7:0] cipher;
        logic       ready;
    } cipher_out_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] cipher_byte;
    logic       table_ready;

    logic [4:0]  key_table [ALPHA_SIZE];
    logic [25:0] used_set;
    logic [4:0]  fill_level;

    cipher_out_t cipher_expect [$];
    stim_row_t   directed_rows [DIRECTED_ROWS];

    int  err_count;
    int  request_count;
    int  result_count;
    int  ready_count;
    int  finish_count;
    int  idle_cycles;
    bit  steady;
    bit  hold_req;

    keyword_substitution_cipher_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cipher_byte (cipher_byte),
        .table_ready (table_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic bit add_letter(int idx);
        if (fill_level >= ALPHA_SIZE || used_set[idx])
            return 1'b0;
        key_table[fill_level] = idx[4:0];
        fill_level = fill_level + 5'd1;
        used_set[idx] = 1'b1;
        return 1'b1;
    endfunction

    // Advance the table state; return 1 when the request yields an enciphered byte.
    function automatic bit cipher_predict(input op_t op, input logic [7:0] b,
                                          output cipher_out_t res, output bit changed);
        int p;
        changed = 1'b0;
        res.cipher = b;
        res.ready = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                used_set = '0;
                fill_level = '0;
                changed = 1'b1;
                return 1'b0;
            end
            OP_KEY:
            begin
                if (b >= LETTER_A && b <= LETTER_Z)
                    changed = add_letter(int'(b - LETTER_A));
                return 1'b0;
            end
            OP_FINISH:
            begin
                for (p = ALPHA_SIZE - 1; p >= 0; p--)
                    if (add_letter(p))
                        changed = 1'b1;
                return 1'b0;
            end
            default:
            begin
                if (b >= LETTER_A && b <= LETTER_Z)
                begin
                    p = int'(b - LETTER_A);
                    if (p < fill_level)
                    begin
                        res.cipher = 8'(LETTER_A + key_table[p]);
                        res.ready = 1'b1;
                    end
                end
                return 1'b1;
            end
        endcase
    endfunction

    task automatic send_request(input op_t op, input logic [7:0] b, input bit typed,
                                input logic [7:0] want_byte, input logic want_ready,
                                output bit changed);
        cipher_out_t res;
        bit gives;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        request_count++;
        if (op == OP_FINISH)
            finish_count++;
        gives = cipher_predict(op, b, res, changed);
        if (gives)
        begin
            if (typed)
            begin
                res.cipher = want_byte;
                res.ready = want_ready;
            end
            cipher_expect.push_back(res);
        end
    endtask

    task automatic send_random(input op_t op, input logic [7:0] b, inout int counted);
        bit changed;
        send_request(op, b, 1'b0, 8'h00, 1'b0, changed);
        counted++;
    endtask

    function automatic logic [7:0] pick_byte(int letter_pct);
        if ($urandom_range(0, 99) < letter_pct)
            return 8'(LETTER_A + $urandom_range(0, ALPHA_SIZE - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int k;
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                for (k = 0; k < HOLD_OFF_CYCLES; k++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            else
            begin
                out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        cipher_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                result_count++;
                if (table_ready)
                    ready_count++;
                if (cipher_expect.size() == 0)
                begin
                    $error("unexpected result: cipher_byte %h, table_ready %b",
                           cipher_byte, table_ready);
                    err_count++;
                end
                else
                begin
                    want = cipher_expect.pop_front();
                    if (cipher_byte !== want.cipher)
                    begin
                        $error("cipher_byte: expected %h, actual %h", want.cipher, cipher_byte);
                        err_count++;
                    end
                    if (table_ready !== want.ready)
                    begin
                        $error("table_ready: expected %b, actual %b", want.ready, table_ready);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
                $display("** keyword_substitution_cipher_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int counted;
        int seq_len;
        bit changed;
        bit held;
        bit paused;

        err_count = 0;
        request_count = 0;
        result_count = 0;
        ready_count = 0;
        finish_count = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        held = 1'b0;
        paused = 1'b0;
        used_set = '0;
        fill_level = '0;
        for (i = 0; i < ALPHA_SIZE; i++)
            key_table[i] = '0;

        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_CLEAR;
        data_byte = 8'h00;

        directed_rows = '{
            '{OP_ENCIPHER, "a",   1'b1, "a",   1'b0},
            '{OP_ENCIPHER, 8'h00, 1'b1, 8'h00, 1'b0},
            '{OP_ENCIPHER, 8'hFF, 1'b1, 8'hFF, 1'b0},
            '{OP_ENCIPHER, "z",   1'b1, "z",   1'b0},
            '{OP_KEY,      "z",   1'b0, 8'h00, 1'b0},
            '{OP_KEY,      "e",   1'b0, 8'h00, 1'b0},
            '{OP_KEY,      "z",   1'b0, 8'h00, 1'b0},
            '{OP_KEY,      "A",   1'b0, 8'h00, 1'b0},
            '{OP_KEY,      8'h60, 1'b0, 8'h00, 1'b0},
            '{OP_KEY,      8'h7B, 1'b0, 8'h00, 1'b0},
            '{OP_ENCIPHER, "a",   1'b0, 8'h00, 1'b0},
            '{OP_ENCIPHER, "b",   1'b0, 8'h00, 1'b0},
            '{OP_ENCIPHER, "c",   1'b0, 8'h00, 1'b0},
            '{OP_FINISH,   8'h00, 1'b0, 8'h00, 1'b0},
            '{OP_FINISH,   8'hFF, 1'b0, 8'h00, 1'b0},
            '{OP_KEY,      "q",   1'b0, 8'h00, 1'b0},
            '{OP_ENCIPHER, "z",   1'b0, 8'h00, 1'b0},
            '{OP_ENCIPHER, "c",   1'b0, 8'h00, 1'b0},
            '{OP_CLEAR,    8'hFF, 1'b0, 8'h00, 1'b0},
            '{OP_ENCIPHER, "a",   1'b1, "a",   1'b0},
            '{OP_FINISH,   8'hAA, 1'b0, 8'h00, 1'b0},
            '{OP_ENCIPHER, "a",   1'b1, "z",   1'b1},
            '{OP_ENCIPHER, "z",   1'b1, "a",   1'b1},
            '{OP_ENCIPHER, 8'h80, 1'b1, 8'h80, 1'b0},
            '{OP_ENCIPHER, 8'h7F, 1'b1, 8'h7F, 1'b0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i].op, directed_rows[i].in_byte, directed_rows[i].typed,
                         directed_rows[i].want_byte, directed_rows[i].want_ready, changed);

        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            steady = (counted >= 450 && counted < 620);
            if (!held && counted >= 300)
            begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && counted >= 750)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (cipher_expect.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                seq_len = $urandom_range(1, 4);
                for (i = 0; i < seq_len; i++)
                    send_random(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), counted);
            end
            else
            begin
                if ($urandom_range(0, 7) != 0)
                    send_random(OP_CLEAR, 8'($urandom_range(0, 255)), counted);
                seq_len = $urandom_range(0, 12);
                for (i = 0; i < seq_len; i++)
                    send_random(OP_KEY, pick_byte(90), counted);
                if ($urandom_range(0, 4) != 0)
                    send_random(OP_FINISH, 8'($urandom_range(0, 255)), counted);
                if ($urandom_range(0, 5) == 0)
                    send_random(op_t'($urandom_range(1, 2)), pick_byte(80), counted);
                seq_len = $urandom_range(4, 30);
                for (i = 0; i < seq_len; i++)
                    send_random(OP_ENCIPHER, pick_byte(85), counted);
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);

        while (cipher_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d from the directed table, %0d finish requests);",
                 request_count, DIRECTED_ROWS, finish_count);
        $display("checked %0d enciphered bytes, %0d of them through a filled table entry.",
                 result_count, ready_count);
        if (err_count == 0 && cipher_expect.size() == 0)
            $display("** keyword_substitution_cipher_core: PASSED **");
        else
            $display("** keyword_substitution_cipher_core: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ksc_pkg.sv
rtl/ksc_front.sv
rtl/ksc_queue.sv
rtl/ksc_back.sv
rtl/keyword_substitution_cipher_core.sv
dv/keyword_substitution_cipher_core_test.sv
